// File: rtl/file_slot_directory_allocator_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the slot directory allocator
// Shared concurrent assertion forms used by the checker.
// ----------------------------------------------------------------------------
`ifndef FILE_SLOT_DIRECTORY_ALLOCATOR_UNIT_MACROS_SVH
`define FILE_SLOT_DIRECTORY_ALLOCATOR_UNIT_MACROS_SVH

// The property holds at every clock edge outside reset.
`define FSD_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("slot directory assertion failed");

// The consequent holds in the cycle after the antecedent.
`define FSD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("slot directory assertion failed");

`endif

// File: rtl/fsd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slot directory allocator package
// Field widths, request and status codes, and the types shared by the cells.
// ----------------------------------------------------------------------------
package fsd_pkg;

    localparam int KIND_W      = 3;
    localparam int NAME_LOW_W  = 64;
    localparam int NAME_HIGH_W = 56;
    localparam int SIZE_W      = 10;
    localparam int BUF_W       = 11;
    localparam int STATUS_W    = 3;
    localparam int SLOT_W      = 4;
    localparam int ADDR_W      = 10;
    localparam int COUNT_W     = 4;
    localparam int NAME_BYTES  = 15;

    localparam logic [KIND_W-1:0] KIND_FORMAT     = 3'd0;
    localparam logic [KIND_W-1:0] KIND_WRITE      = 3'd1;
    localparam logic [KIND_W-1:0] KIND_SAFE_WRITE = 3'd2;
    localparam logic [KIND_W-1:0] KIND_READ       = 3'd3;
    localparam logic [KIND_W-1:0] KIND_DELETE     = 3'd4;
    localparam logic [KIND_W-1:0] KIND_EXISTS     = 3'd5;

    localparam logic [STATUS_W-1:0] STATUS_OK          = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_UNFORMATTED = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_NO_SPACE    = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_TABLE_FULL  = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND   = 3'd4;
    localparam logic [STATUS_W-1:0] STATUS_BUF_SMALL   = 3'd5;

    typedef enum logic [1:0] {
        MODE_REUSE,
        MODE_ALLOC,
        MODE_FIND,
        MODE_DELETE
    } mode_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_REUSE,
        S_ALLOC,
        S_FIND,
        S_RESP
    } state_t;

    typedef struct packed {
        logic  valid;
        mode_t mode;
        logic  hit;
    } tok_t;

    typedef struct packed {
        logic [NAME_LOW_W-1:0]  name_low;
        logic [NAME_HIGH_W-1:0] name_high;
        logic [SIZE_W-1:0]      size;
    } req_t;

endpackage

// File: rtl/fsd_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slot directory allocator channels
// Request and response channels with a valid and ready handshake.
// ----------------------------------------------------------------------------
interface fsd_req_if;
    logic                                valid;
    logic                                ready;
    logic [fsd_pkg::KIND_W-1:0]          kind;
    logic [fsd_pkg::NAME_LOW_W-1:0]      name_low;
    logic [fsd_pkg::NAME_HIGH_W-1:0]     name_high;
    logic [fsd_pkg::SIZE_W-1:0]          content_length;
    logic [fsd_pkg::BUF_W-1:0]           buffer_size;

    modport source (output valid, kind, name_low, name_high, content_length, buffer_size,
                    input ready);
    modport sink   (input valid, kind, name_low, name_high, content_length, buffer_size,
                    output ready);
endinterface

interface fsd_rsp_if;
    logic                                valid;
    logic                                ready;
    logic [fsd_pkg::STATUS_W-1:0]        status;
    logic [fsd_pkg::SLOT_W-1:0]          slot_index;
    logic [fsd_pkg::ADDR_W-1:0]          start_address;
    logic [fsd_pkg::SIZE_W-1:0]          file_length;
    logic [fsd_pkg::COUNT_W-1:0]         free_slot_count;
    logic [fsd_pkg::ADDR_W-1:0]          free_bytes;

    modport source (output valid, status, slot_index, start_address, file_length,
                    free_slot_count, free_bytes, input ready);
    modport sink   (input valid, status, slot_index, start_address, file_length,
                    free_slot_count, free_bytes, output ready);
endinterface

// File: rtl/fsd_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slot directory cell
// Holds one slot and passes the search token to its neighbor each cycle.
// ----------------------------------------------------------------------------
module fsd_cell #(
    parameter int IW = 4,
    parameter int PW = 11
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  fsd_pkg::req_t                 req,
    input  logic [PW-1:0]                 bump,
    input  logic                          clear,
    input  logic [IW-1:0]                 cell_index,
    input  fsd_pkg::tok_t                 tok_in,
    input  logic [IW-1:0]                 idx_in,
    input  logic [PW-1:0]                 start_in,
    input  logic [fsd_pkg::SIZE_W-1:0]    len_in,
    output fsd_pkg::tok_t                 tok_out,
    output logic [IW-1:0]                 idx_out,
    output logic [PW-1:0]                 start_out,
    output logic [fsd_pkg::SIZE_W-1:0]    len_out
);

    logic                              active_reg, active_next;
    logic [fsd_pkg::NAME_LOW_W-1:0]    name_low_reg, name_low_next;
    logic [fsd_pkg::NAME_HIGH_W-1:0]   name_high_reg, name_high_next;
    logic [PW-1:0]                     start_reg, start_next;
    logic [fsd_pkg::SIZE_W-1:0]        len_reg, len_next;
    fsd_pkg::tok_t                     tok_reg, tok_next;
    logic [IW-1:0]                     idx_o_reg, idx_o_next;
    logic [PW-1:0]                     start_o_reg, start_o_next;
    logic [fsd_pkg::SIZE_W-1:0]        len_o_reg, len_o_next;
    logic                              match;
    logic                              cond;
    logic                              claim;

    always_comb
    begin
        match = active_reg && (name_low_reg == req.name_low)
                && (name_high_reg == req.name_high);
        case (tok_in.mode)
            fsd_pkg::MODE_REUSE:
                cond = !active_reg && (len_reg >= req.size) && (start_reg != '0);
            fsd_pkg::MODE_ALLOC:
                cond = !active_reg;
            fsd_pkg::MODE_FIND,
            fsd_pkg::MODE_DELETE:
                cond = match;
            default:
                cond = 1'b0;
        endcase
        claim = tok_in.valid && !tok_in.hit && cond;

        active_next    = active_reg;
        name_low_next  = name_low_reg;
        name_high_next = name_high_reg;
        start_next     = start_reg;
        len_next       = len_reg;
        if (clear)
        begin
            active_next = 1'b0;
            start_next  = '0;
            len_next    = '0;
        end
        else if (claim)
        begin
            case (tok_in.mode)
                fsd_pkg::MODE_REUSE:
                begin
                    active_next    = 1'b1;
                    name_low_next  = req.name_low;
                    name_high_next = req.name_high;
                    len_next       = req.size;
                end
                fsd_pkg::MODE_ALLOC:
                begin
                    active_next    = 1'b1;
                    name_low_next  = req.name_low;
                    name_high_next = req.name_high;
                    len_next       = req.size;
                    start_next     = bump;
                end
                fsd_pkg::MODE_DELETE:
                    active_next = 1'b0;
                default:
                    active_next = active_reg;
            endcase
        end

        tok_next     = tok_in;
        tok_next.hit = tok_in.hit || claim;
        idx_o_next   = claim ? cell_index : idx_in;
        start_o_next = claim ? start_next : start_in;
        len_o_next   = claim ? len_next : len_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            start_reg  <= '0;
            len_reg    <= '0;
            tok_reg    <= '{valid: 1'b0, mode: fsd_pkg::MODE_FIND, hit: 1'b0};
        end
        else
        begin
            active_reg <= active_next;
            start_reg  <= start_next;
            len_reg    <= len_next;
            tok_reg    <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        name_low_reg  <= name_low_next;
        name_high_reg <= name_high_next;
        idx_o_reg     <= idx_o_next;
        start_o_reg   <= start_o_next;
        len_o_reg     <= len_o_next;
    end

    assign tok_out   = tok_reg;
    assign idx_out   = idx_o_reg;
    assign start_out = start_o_reg;
    assign len_out   = len_o_reg;

endmodule

// File: rtl/file_slot_directory_allocator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slot directory allocator
// Directory and bump allocator for a small byte store, built as a row of
// slot cells that a search token walks through one cell per cycle.
// ----------------------------------------------------------------------------
//  Channel    Direction  Contents
//  request    in         kind, name_low, name_high, content_length, buffer_size
//  response   out        status, slot_index, start_address, file_length,
//                        free_slot_count, free_bytes
//
//  One item is in work at a time; request is ready only when the block is idle.
//  Format and requests rejected up front put the response out in the cycle
//  after acceptance. Reads, deletes, exists and writes run one pass of the
//  token down the slot row before the response goes out; a write that finds no
//  slot to reuse and has space runs a second pass to allocate. Request reopens
//  in the cycle after the response is taken. Reset empties the table and
//  leaves the store unformatted; a stalled response holds until taken.
// ----------------------------------------------------------------------------
module file_slot_directory_allocator_unit #(
    parameter int SLOT_COUNT  = 10,
    parameter int STORE_BYTES = 1024,
    parameter int DATA_START  = 211
) (
    input  logic        clk,
    input  logic        rst_n,
    fsd_req_if.sink     request,
    fsd_rsp_if.source   response
);

    localparam int IW     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int TOP_P  = (STORE_BYTES > DATA_START) ? STORE_BYTES : DATA_START;
    localparam int PW     = $clog2(TOP_P + 1);
    localparam int CW     = $clog2(SLOT_COUNT + 1);
    localparam int SW     = (PW > fsd_pkg::SIZE_W) ? PW : fsd_pkg::SIZE_W;
    localparam logic [PW-1:0] STORE_P = PW'(STORE_BYTES);
    localparam logic [PW-1:0] DATA_P  = PW'(DATA_START);
    localparam logic [CW-1:0] SLOTS_P = CW'(SLOT_COUNT);
    localparam int NAME_W = fsd_pkg::NAME_LOW_W + fsd_pkg::NAME_HIGH_W;

    fsd_pkg::state_t                 state_reg, state_next;
    logic [fsd_pkg::KIND_W-1:0]      kind_reg, kind_next;
    fsd_pkg::req_t                   req_reg, req_next;
    logic [fsd_pkg::BUF_W-1:0]       bufsz_reg, bufsz_next;
    logic [PW-1:0]                   bump_reg, bump_next;
    logic                            formatted_reg, formatted_next;
    logic [CW-1:0]                   free_cnt_reg, free_cnt_next;
    logic [fsd_pkg::STATUS_W-1:0]    status_reg, status_next;
    logic [fsd_pkg::SLOT_W-1:0]      slot_reg, slot_next;
    logic [fsd_pkg::ADDR_W-1:0]      start_reg, start_next;
    logic [fsd_pkg::SIZE_W-1:0]      len_reg, len_next;
    fsd_pkg::tok_t                   launch_reg, launch_next;

    fsd_pkg::tok_t                   tok_w   [0:SLOT_COUNT];
    logic [IW-1:0]                   idx_w   [0:SLOT_COUNT];
    logic [PW-1:0]                   start_w [0:SLOT_COUNT];
    logic [fsd_pkg::SIZE_W-1:0]      len_w   [0:SLOT_COUNT];

    logic [NAME_W-1:0]               name_in;
    logic [NAME_W-1:0]               name_mask;
    logic [fsd_pkg::NAME_BYTES-1:0]  byte_keep;
    logic [PW-1:0]                   free_space;
    logic                            short_in;
    logic                            short_reg;
    logic                            clear;
    fsd_pkg::tok_t                   last_tok;
    logic [fsd_pkg::BUF_W-1:0]       need;

    always_comb
    begin
        name_in        = {request.name_high, request.name_low};
        byte_keep[0]   = (name_in[7:0] != 8'h00);
        name_mask[7:0] = {8{byte_keep[0]}};
        for (int b = 1; b < fsd_pkg::NAME_BYTES; b++)
        begin
            byte_keep[b]        = byte_keep[b-1] && (name_in[8*b +: 8] != 8'h00);
            name_mask[8*b +: 8] = {8{byte_keep[b]}};
        end
    end

    assign free_space = (formatted_reg && (bump_reg < STORE_P)) ? (STORE_P - bump_reg) : '0;
    assign short_in   = SW'(free_space) < SW'(request.content_length);
    assign short_reg  = SW'(free_space) < SW'(req_reg.size);
    assign clear      = (state_reg == fsd_pkg::S_IDLE) && request.valid
                        && (request.kind == fsd_pkg::KIND_FORMAT);
    assign last_tok   = tok_w[SLOT_COUNT];
    assign need       = {1'b0, len_w[SLOT_COUNT]} + 11'd1;

    assign tok_w[0]   = launch_reg;
    assign idx_w[0]   = '0;
    assign start_w[0] = '0;
    assign len_w[0]   = '0;

    for (genvar i = 0; i < SLOT_COUNT; i++)
    begin : g_cell
        fsd_cell #(
            .IW (IW),
            .PW (PW)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .req        (req_reg),
            .bump       (bump_reg),
            .clear      (clear),
            .cell_index (IW'(i)),
            .tok_in     (tok_w[i]),
            .idx_in     (idx_w[i]),
            .start_in   (start_w[i]),
            .len_in     (len_w[i]),
            .tok_out    (tok_w[i+1]),
            .idx_out    (idx_w[i+1]),
            .start_out  (start_w[i+1]),
            .len_out    (len_w[i+1])
        );
    end

    always_comb
    begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        req_next       = req_reg;
        bufsz_next     = bufsz_reg;
        bump_next      = bump_reg;
        formatted_next = formatted_reg;
        free_cnt_next  = free_cnt_reg;
        status_next    = status_reg;
        slot_next      = slot_reg;
        start_next     = start_reg;
        len_next       = len_reg;
        launch_next    = '{valid: 1'b0, mode: fsd_pkg::MODE_FIND, hit: 1'b0};

        case (state_reg)
            fsd_pkg::S_IDLE:
            begin
                if (request.valid)
                begin
                    kind_next          = request.kind;
                    req_next.name_low  = request.name_low & name_mask[fsd_pkg::NAME_LOW_W-1:0];
                    req_next.name_high = request.name_high
                                         & name_mask[NAME_W-1:fsd_pkg::NAME_LOW_W];
                    req_next.size      = request.content_length;
                    bufsz_next         = request.buffer_size;
                    slot_next          = '0;
                    start_next         = '0;
                    len_next           = '0;
                    state_next         = fsd_pkg::S_RESP;
                    case (request.kind)
                        fsd_pkg::KIND_FORMAT:
                        begin
                            bump_next      = DATA_P;
                            formatted_next = 1'b1;
                            free_cnt_next  = SLOTS_P;
                            status_next    = fsd_pkg::STATUS_OK;
                        end
                        fsd_pkg::KIND_WRITE,
                        fsd_pkg::KIND_SAFE_WRITE:
                        begin
                            if ((request.kind == fsd_pkg::KIND_SAFE_WRITE) && short_in)
                                status_next = fsd_pkg::STATUS_NO_SPACE;
                            else if (!formatted_reg)
                                status_next = fsd_pkg::STATUS_UNFORMATTED;
                            else
                            begin
                                launch_next = '{valid: 1'b1, mode: fsd_pkg::MODE_REUSE,
                                                hit: 1'b0};
                                state_next  = fsd_pkg::S_REUSE;
                            end
                        end
                        fsd_pkg::KIND_READ:
                        begin
                            if (!formatted_reg)
                                status_next = fsd_pkg::STATUS_UNFORMATTED;
                            else
                            begin
                                launch_next = '{valid: 1'b1, mode: fsd_pkg::MODE_FIND,
                                                hit: 1'b0};
                                state_next  = fsd_pkg::S_FIND;
                            end
                        end
                        fsd_pkg::KIND_DELETE:
                        begin
                            launch_next = '{valid: 1'b1, mode: fsd_pkg::MODE_DELETE, hit: 1'b0};
                            state_next  = fsd_pkg::S_FIND;
                        end
                        fsd_pkg::KIND_EXISTS:
                        begin
                            launch_next = '{valid: 1'b1, mode: fsd_pkg::MODE_FIND, hit: 1'b0};
                            state_next  = fsd_pkg::S_FIND;
                        end
                        default:
                            status_next = fsd_pkg::STATUS_NOT_FOUND;
                    endcase
                end
            end
            fsd_pkg::S_REUSE:
            begin
                if (last_tok.valid)
                begin
                    if (last_tok.hit)
                    begin
                        status_next   = fsd_pkg::STATUS_OK;
                        slot_next     = fsd_pkg::SLOT_W'(idx_w[SLOT_COUNT]);
                        start_next    = fsd_pkg::ADDR_W'(start_w[SLOT_COUNT]);
                        len_next      = len_w[SLOT_COUNT];
                        free_cnt_next = free_cnt_reg - CW'(1);
                        state_next    = fsd_pkg::S_RESP;
                    end
                    else if (short_reg)
                    begin
                        status_next = fsd_pkg::STATUS_NO_SPACE;
                        state_next  = fsd_pkg::S_RESP;
                    end
                    else
                    begin
                        launch_next = '{valid: 1'b1, mode: fsd_pkg::MODE_ALLOC, hit: 1'b0};
                        state_next  = fsd_pkg::S_ALLOC;
                    end
                end
            end
            fsd_pkg::S_ALLOC:
            begin
                if (last_tok.valid)
                begin
                    state_next = fsd_pkg::S_RESP;
                    if (last_tok.hit)
                    begin
                        status_next   = fsd_pkg::STATUS_OK;
                        slot_next     = fsd_pkg::SLOT_W'(idx_w[SLOT_COUNT]);
                        start_next    = fsd_pkg::ADDR_W'(start_w[SLOT_COUNT]);
                        len_next      = len_w[SLOT_COUNT];
                        free_cnt_next = free_cnt_reg - CW'(1);
                        bump_next     = bump_reg + PW'(req_reg.size);
                    end
                    else
                        status_next = fsd_pkg::STATUS_TABLE_FULL;
                end
            end
            fsd_pkg::S_FIND:
            begin
                if (last_tok.valid)
                begin
                    state_next = fsd_pkg::S_RESP;
                    if (!last_tok.hit)
                        status_next = fsd_pkg::STATUS_NOT_FOUND;
                    else
                    begin
                        slot_next   = fsd_pkg::SLOT_W'(idx_w[SLOT_COUNT]);
                        start_next  = fsd_pkg::ADDR_W'(start_w[SLOT_COUNT]);
                        len_next    = len_w[SLOT_COUNT];
                        status_next = fsd_pkg::STATUS_OK;
                        if ((kind_reg == fsd_pkg::KIND_READ) && (bufsz_reg < need))
                            status_next = fsd_pkg::STATUS_BUF_SMALL;
                        if (kind_reg == fsd_pkg::KIND_DELETE)
                            free_cnt_next = free_cnt_reg + CW'(1);
                    end
                end
            end
            fsd_pkg::S_RESP:
            begin
                if (response.ready)
                    state_next = fsd_pkg::S_IDLE;
            end
            default:
                state_next = fsd_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fsd_pkg::S_IDLE;
            bump_reg      <= DATA_P;
            formatted_reg <= 1'b0;
            free_cnt_reg  <= SLOTS_P;
            launch_reg    <= '{valid: 1'b0, mode: fsd_pkg::MODE_FIND, hit: 1'b0};
        end
        else
        begin
            state_reg     <= state_next;
            bump_reg      <= bump_next;
            formatted_reg <= formatted_next;
            free_cnt_reg  <= free_cnt_next;
            launch_reg    <= launch_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg   <= kind_next;
        req_reg    <= req_next;
        bufsz_reg  <= bufsz_next;
        status_reg <= status_next;
        slot_reg   <= slot_next;
        start_reg  <= start_next;
        len_reg    <= len_next;
    end

    assign request.ready            = (state_reg == fsd_pkg::S_IDLE);
    assign response.valid           = (state_reg == fsd_pkg::S_RESP);
    assign response.status          = status_reg;
    assign response.slot_index      = slot_reg;
    assign response.start_address   = start_reg;
    assign response.file_length     = len_reg;
    assign response.free_slot_count = formatted_reg ? fsd_pkg::COUNT_W'(free_cnt_reg) : '0;
    assign response.free_bytes      = fsd_pkg::ADDR_W'(free_space);

endmodule

// File: rtl/fsd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slot directory allocator checker
// Watches the ports of the allocator and checks how they relate over time.
// ----------------------------------------------------------------------------
`include "file_slot_directory_allocator_unit_macros.svh"

module fsd_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              req_valid,
    input logic                              req_ready,
    input logic                              rsp_valid,
    input logic                              rsp_ready,
    input logic [fsd_pkg::STATUS_W-1:0]      status,
    input logic [fsd_pkg::SLOT_W-1:0]        slot_index,
    input logic [fsd_pkg::ADDR_W-1:0]        start_address,
    input logic [fsd_pkg::SIZE_W-1:0]        file_length,
    input logic [fsd_pkg::COUNT_W-1:0]       free_slot_count,
    input logic [fsd_pkg::ADDR_W-1:0]        free_bytes
);

    // Only one item is in work, so a pending result closes the request side.
    `FSD_ASSERT(a_no_accept_with_result, clk, rst_n, rsp_valid |-> !req_ready)
    `FSD_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, req_valid && req_ready, !req_ready)
    // A failed request, other than a read with too small a buffer, carries no file.
    `FSD_ASSERT(a_fail_no_file, clk, rst_n, (rsp_valid && (status != fsd_pkg::STATUS_OK) && (status != fsd_pkg::STATUS_BUF_SMALL)) |-> ((slot_index == '0) && (start_address == '0) && (file_length == '0)))
    `FSD_ASSERT(a_unformatted_empty, clk, rst_n, (rsp_valid && (status == fsd_pkg::STATUS_UNFORMATTED)) |-> ((free_slot_count == '0) && (free_bytes == '0)))
    `FSD_ASSERT_NEXT(a_result_holds, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(status) && $stable(slot_index) && $stable(file_length))

endmodule

bind file_slot_directory_allocator_unit fsd_checker u_fsd_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_valid       (request.valid),
    .req_ready       (request.ready),
    .rsp_valid       (response.valid),
    .rsp_ready       (response.ready),
    .status          (response.status),
    .slot_index      (response.slot_index),
    .start_address   (response.start_address),
    .file_length     (response.file_length),
    .free_slot_count (response.free_slot_count),
    .free_bytes      (response.free_bytes)
);

// File: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slot directory allocator testbench
// Drives format, write, safe write, read, delete and exists requests into the
// allocator, first from a short table of directed rows and then as random
// traffic over a small pool of file names. A directory model in the bench
// tracks the slot table, the bump pointer and the formatted flag, predicts
// every response, and each response is compared field by field in order.
// Both channels idle and stall at random, with one stretch of full speed.
// ----------------------------------------------------------------------------
module tb_top;
    import fsd_pkg::*;

    localparam int SLOT_COUNT     = 10;
    localparam int STORE_BYTES    = 1024;
    localparam int DATA_START     = 211;
    localparam int NAME_W         = NAME_LOW_W + NAME_HIGH_W;
    localparam int NAME_POOL      = 10;
    localparam int DIRECTED_ROWS  = 26;
    localparam int RANDOM_ITEMS   = 1225;
    localparam int IDLE_PCT       = 24;
    localparam int DRAIN_CYCLES   = 40;
    localparam int CYCLE_LIMIT    = 400000;

    localparam logic [KIND_W-1:0] KIND_SPARE_A = 3'd6;
    localparam logic [KIND_W-1:0] KIND_SPARE_B = 3'd7;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot_index;
        logic [ADDR_W-1:0]   start_address;
        logic [SIZE_W-1:0]   file_length;
        logic [COUNT_W-1:0]  free_slot_count;
        logic [ADDR_W-1:0]   free_bytes;
    } reply_t;

    typedef struct packed {
        logic [KIND_W-1:0]      kind;
        logic [NAME_LOW_W-1:0]  name_low;
        logic [NAME_HIGH_W-1:0] name_high;
        logic [SIZE_W-1:0]      content_length;
        logic [BUF_W-1:0]       buffer_size;
        logic                   fixed;
        reply_t                 reply;
    } dir_row_t;

    localparam reply_t NO_REPLY = '0;
    localparam logic [NAME_LOW_W-1:0]  ALL_LOW  = '1;
    localparam logic [NAME_HIGH_W-1:0] ALL_HIGH = '1;

    logic clk = 1'b0;
    logic rst_n;
    bit   steady;
    int   mismatches;
    int   cycle_count;

    fsd_req_if request_ch();
    fsd_rsp_if response_ch();

    file_slot_directory_allocator_unit #(
        .SLOT_COUNT  (SLOT_COUNT),
        .STORE_BYTES (STORE_BYTES),
        .DATA_START  (DATA_START)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .request  (request_ch),
        .response (response_ch)
    );

    always #10 clk = ~clk;

    // Directory model state.
    logic              slot_used [SLOT_COUNT];
    logic [NAME_W-1:0] slot_name [SLOT_COUNT];
    int                slot_base [SLOT_COUNT];
    int                slot_size [SLOT_COUNT];
    int                bump;
    bit                formatted;

    reply_t            awaited_replies [$];

    logic [NAME_W-1:0] name_pool [NAME_POOL];
    int                name_len  [NAME_POOL];

    dir_row_t directed_rows [DIRECTED_ROWS] = '{
        '{KIND_WRITE, 64'h41, 56'h0, 10'd5, 11'd0, 1'b1,
          '{STATUS_UNFORMATTED, 4'd0, 10'd0, 10'd0, 4'd0, 10'd0}},
        '{KIND_READ, 64'h41, 56'h0, 10'd0, 11'd2047, 1'b1,
          '{STATUS_UNFORMATTED, 4'd0, 10'd0, 10'd0, 4'd0, 10'd0}},
        '{KIND_DELETE, 64'h41, 56'h0, 10'd0, 11'd0, 1'b1,
          '{STATUS_NOT_FOUND, 4'd0, 10'd0, 10'd0, 4'd0, 10'd0}},
        '{KIND_EXISTS, 64'h41, 56'h0, 10'd0, 11'd0, 1'b1,
          '{STATUS_NOT_FOUND, 4'd0, 10'd0, 10'd0, 4'd0, 10'd0}},
        '{KIND_SAFE_WRITE, 64'h41, 56'h0, 10'd1023, 11'd0, 1'b1,
          '{STATUS_NO_SPACE, 4'd0, 10'd0, 10'd0, 4'd0, 10'd0}},
        '{KIND_SAFE_WRITE, 64'h41, 56'h0, 10'd0, 11'd0, 1'b1,
          '{STATUS_UNFORMATTED, 4'd0, 10'd0, 10'd0, 4'd0, 10'd0}},
        '{KIND_SPARE_A, 64'h41, 56'h0, 10'd0, 11'd0, 1'b1,
          '{STATUS_NOT_FOUND, 4'd0, 10'd0, 10'd0, 4'd0, 10'd0}},
        '{KIND_SPARE_B, 64'h41, 56'h0, 10'd0, 11'd0, 1'b1,
          '{STATUS_NOT_FOUND, 4'd0, 10'd0, 10'd0, 4'd0, 10'd0}},
        '{KIND_FORMAT, 64'h0, 56'h0, 10'd0, 11'd0, 1'b1,
          '{STATUS_OK, 4'd0, 10'd0, 10'd0, 4'd10, 10'd813}},
        '{KIND_WRITE, ALL_LOW, ALL_HIGH, 10'd1023, 11'd0, 1'b1,
          '{STATUS_NO_SPACE, 4'd0, 10'd0, 10'd0, 4'd10, 10'd813}},
        '{KIND_WRITE, ALL_LOW, ALL_HIGH, 10'd813, 11'd0, 1'b1,
          '{STATUS_OK, 4'd0, 10'd211, 10'd813, 4'd9, 10'd0}},
        '{KIND_WRITE, 64'h42, 56'h0, 10'd0, 11'd0, 1'b0, NO_REPLY},
        '{KIND_READ, 64'hFFFF_FF00_0000_0042, 56'h0, 10'd0, 11'd0, 1'b0, NO_REPLY},
        '{KIND_READ, ALL_LOW, ALL_HIGH, 10'd0, 11'd2047, 1'b0, NO_REPLY},
        '{KIND_READ, ALL_LOW, ALL_HIGH, 10'd0, 11'd813, 1'b0, NO_REPLY},
        '{KIND_DELETE, ALL_LOW, ALL_HIGH, 10'd0, 11'd0, 1'b0, NO_REPLY},
        '{KIND_WRITE, 64'h43, 56'hAB, 10'd500, 11'd0, 1'b0, NO_REPLY},
        '{KIND_EXISTS, 64'h43, 56'h0, 10'd0, 11'd0, 1'b0, NO_REPLY},
        '{KIND_DELETE, 64'h42, 56'h0, 10'd0, 11'd0, 1'b0, NO_REPLY},
        '{KIND_WRITE, 64'h44, 56'h0, 10'd0, 11'd0, 1'b0, NO_REPLY},
        '{KIND_WRITE, 64'h0, ALL_HIGH, 10'd0, 11'd0, 1'b0, NO_REPLY},
        '{KIND_SAFE_WRITE, 64'h45, 56'h0, 10'd1, 11'd0, 1'b0, NO_REPLY},
        '{KIND_WRITE, 64'h45, 56'h0, 10'd1, 11'd0, 1'b0, NO_REPLY},
        '{KIND_DELETE, 64'h43, 56'h0, 10'd0, 11'd0, 1'b0, NO_REPLY},
        '{KIND_WRITE, 64'h45, 56'h0, 10'd300, 11'd0, 1'b0, NO_REPLY},
        '{KIND_FORMAT, 64'h0, 56'h0, 10'd0, 11'd0, 1'b0, NO_REPLY}
    };

    function automatic int space_left();
        if (!formatted || bump >= STORE_BYTES)
            return 0;
        return STORE_BYTES - bump;
    endfunction

    function automatic int slots_left();
        int n;
        n = 0;
        if (!formatted)
            return 0;
        for (int i = 0; i < SLOT_COUNT; i++)
            if (!slot_used[i])
                n++;
        return n;
    endfunction

    function automatic int lookup_file(input logic [NAME_W-1:0] name);
        for (int i = 0; i < SLOT_COUNT; i++)
            if (slot_used[i] && slot_name[i] == name)
                return i;
        return -1;
    endfunction

    task automatic clear_directory();
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            slot_used[i] = 1'b0;
            slot_name[i] = '0;
            slot_base[i] = 0;
            slot_size[i] = 0;
        end
        bump = DATA_START;
    endtask

    task automatic directory_step(input logic [KIND_W-1:0] kind,
                                  input logic [NAME_LOW_W-1:0] lo,
                                  input logic [NAME_HIGH_W-1:0] hi,
                                  input logic [SIZE_W-1:0] len,
                                  input logic [BUF_W-1:0] bufsz,
                                  output reply_t r);
        logic [NAME_W-1:0]   name;
        logic [STATUS_W-1:0] status;
        bit                  ended;
        int                  slot;
        int                  size;

        name   = {hi, lo};
        ended  = 1'b0;
        status = STATUS_NOT_FOUND;
        slot   = -1;
        size   = int'(len);
        for (int b = 0; b < NAME_BYTES; b++)
        begin
            if (name[8*b +: 8] == 8'h00)
                ended = 1'b1;
            if (ended)
                name[8*b +: 8] = 8'h00;
        end

        case (kind)
            KIND_FORMAT:
            begin
                clear_directory();
                formatted = 1'b1;
                status = STATUS_OK;
            end
            KIND_WRITE, KIND_SAFE_WRITE:
            begin
                if (kind == KIND_SAFE_WRITE && space_left() < size)
                    status = STATUS_NO_SPACE;
                else if (!formatted)
                    status = STATUS_UNFORMATTED;
                else
                begin
                    for (int i = 0; i < SLOT_COUNT; i++)
                        if (slot < 0 && !slot_used[i] && slot_size[i] >= size
                            && slot_base[i] > 0)
                            slot = i;
                    if (slot < 0)
                    begin
                        if (space_left() < size)
                            status = STATUS_NO_SPACE;
                        else
                        begin
                            for (int i = 0; i < SLOT_COUNT; i++)
                                if (slot < 0 && !slot_used[i])
                                begin
                                    slot = i;
                                    slot_base[i] = bump;
                                    bump += size;
                                end
                            if (slot < 0)
                                status = STATUS_TABLE_FULL;
                        end
                    end
                    if (slot >= 0)
                    begin
                        slot_used[slot] = 1'b1;
                        slot_name[slot] = name;
                        slot_size[slot] = size;
                        status = STATUS_OK;
                    end
                end
            end
            KIND_READ:
            begin
                if (!formatted)
                    status = STATUS_UNFORMATTED;
                else
                begin
                    slot = lookup_file(name);
                    if (slot < 0)
                        status = STATUS_NOT_FOUND;
                    else if (int'(bufsz) < slot_size[slot] + 1)
                        status = STATUS_BUF_SMALL;
                    else
                        status = STATUS_OK;
                end
            end
            KIND_DELETE:
            begin
                slot = lookup_file(name);
                if (slot >= 0)
                begin
                    slot_used[slot] = 1'b0;
                    status = STATUS_OK;
                end
            end
            KIND_EXISTS:
            begin
                slot = lookup_file(name);
                if (slot >= 0)
                    status = STATUS_OK;
            end
            default:
                status = STATUS_NOT_FOUND;
        endcase

        r = '0;
        r.status = status;
        if (kind != KIND_FORMAT && slot >= 0
            && (status == STATUS_OK || status == STATUS_BUF_SMALL))
        begin
            r.slot_index    = SLOT_W'(slot);
            r.start_address = ADDR_W'(slot_base[slot]);
            r.file_length   = SIZE_W'(slot_size[slot]);
        end
        r.free_slot_count = COUNT_W'(slots_left());
        r.free_bytes      = ADDR_W'(space_left());
    endtask

    task automatic send_request(input logic [KIND_W-1:0] kind,
                                input logic [NAME_LOW_W-1:0] lo,
                                input logic [NAME_HIGH_W-1:0] hi,
                                input logic [SIZE_W-1:0] len,
                                input logic [BUF_W-1:0] bufsz,
                                input logic fixed,
                                input reply_t fixed_reply);
        reply_t predicted;

        if (!steady)
            while ($urandom_range(0, 99) < IDLE_PCT)
            begin
                request_ch.valid <= 1'b0;
                @(negedge clk);
            end
        request_ch.valid          <= 1'b1;
        request_ch.kind           <= kind;
        request_ch.name_low       <= lo;
        request_ch.name_high      <= hi;
        request_ch.content_length <= len;
        request_ch.buffer_size    <= bufsz;
        @(posedge clk);
        while (!request_ch.ready)
            @(posedge clk);
        directory_step(kind, lo, hi, len, bufsz, predicted);
        awaited_replies.push_back(fixed ? fixed_reply : predicted);
        @(negedge clk);
    endtask

    task automatic refresh_name(input int idx);
        logic [NAME_W-1:0] name;
        int                len;

        name = '0;
        len  = $urandom_range(0, 15);
        for (int b = 0; b < len; b++)
            name[8*b +: 8] = 8'($urandom_range(1, 255));
        name_pool[idx] = name;
        name_len[idx]  = len;
    endtask

    task automatic check_field(input string label, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s expected %0d, actual %0d", $time, label, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        reply_t want;
        if (rst_n && response_ch.valid && response_ch.ready)
        begin
            if (awaited_replies.size() == 0)
            begin
                $display("%0t: response item with none expected, expected nothing, actual %0d",
                         $time, response_ch.status);
                mismatches++;
            end
            else
            begin
                want = awaited_replies.pop_front();
                check_field("status", want.status, response_ch.status);
                check_field("slot_index", want.slot_index, response_ch.slot_index);
                check_field("start_address", want.start_address, response_ch.start_address);
                check_field("file_length", want.file_length, response_ch.file_length);
                check_field("free_slot_count", want.free_slot_count,
                            response_ch.free_slot_count);
                check_field("free_bytes", want.free_bytes, response_ch.free_bytes);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        response_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            response_ch.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    initial
    begin
        logic [KIND_W-1:0]  kind;
        logic [NAME_W-1:0]  name;
        logic [SIZE_W-1:0]  len;
        logic [BUF_W-1:0]   bufsz;
        int                 pick;
        int                 found;
        int                 r;

        request_ch.valid          = 1'b0;
        request_ch.kind           = KIND_FORMAT;
        request_ch.name_low       = '0;
        request_ch.name_high      = '0;
        request_ch.content_length = '0;
        request_ch.buffer_size    = '0;
        rst_n       = 1'b0;
        steady      = 1'b0;
        mismatches  = 0;
        cycle_count = 0;
        formatted   = 1'b0;
        clear_directory();
        for (int i = 0; i < NAME_POOL; i++)
            refresh_name(i);

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
            send_request(directed_rows[i].kind, directed_rows[i].name_low,
                         directed_rows[i].name_high, directed_rows[i].content_length,
                         directed_rows[i].buffer_size, directed_rows[i].fixed,
                         directed_rows[i].reply);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            steady = (n >= 500 && n < 750);
            if ($urandom_range(0, 99) < 3)
                refresh_name($urandom_range(0, NAME_POOL - 1));

            r = $urandom_range(0, 99);
            if (r < 2)
                kind = KIND_FORMAT;
            else if (r < 32)
                kind = KIND_WRITE;
            else if (r < 45)
                kind = KIND_SAFE_WRITE;
            else if (r < 68)
                kind = KIND_READ;
            else if (r < 85)
                kind = KIND_DELETE;
            else
                kind = KIND_EXISTS;

            found = -1;
            if ($urandom_range(0, 99) < 90)
            begin
                pick = $urandom_range(0, NAME_POOL - 1);
                name = name_pool[pick];
                found = lookup_file(name);
                if (name_len[pick] < NAME_BYTES && $urandom_range(0, 99) < 25)
                    for (int b = name_len[pick] + 1; b < NAME_BYTES; b++)
                        name[8*b +: 8] = 8'($urandom);
            end
            else
            begin
                name[31:0]   = $urandom;
                name[63:32]  = $urandom;
                name[95:64]  = $urandom;
                name[119:96] = 24'($urandom);
            end

            r = $urandom_range(0, 99);
            if (r < 55)
                len = SIZE_W'($urandom_range(0, 64));
            else if (r < 75)
                len = SIZE_W'($urandom_range(0, 300));
            else if (r < 85)
                len = SIZE_W'($urandom_range(0, 1023));
            else if (r < 92)
                len = SIZE_W'(space_left());
            else if (r < 96)
                len = '1;
            else
                len = '0;

            r = $urandom_range(0, 99);
            if (kind == KIND_READ && found >= 0 && r < 40)
                bufsz = BUF_W'(slot_size[found]);
            else if (kind == KIND_READ && found >= 0 && r < 80)
                bufsz = BUF_W'(slot_size[found] + 1);
            else if (r < 90)
                bufsz = BUF_W'($urandom_range(0, 2047));
            else
                bufsz = BUF_W'($urandom_range(0, 200));

            send_request(kind, name[63:0], name[119:64], len, bufsz, 1'b0, NO_REPLY);
        end
        steady = 1'b0;
        request_ch.valid <= 1'b0;

        while (awaited_replies.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
